// File: src/fbpa_pkg.sv
// fbpa_pkg: shared types and constants of the fixed block pool allocator
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int IDX_W            = 10;
    localparam int CNT_W            = 11;
    localparam int BS_W             = 16;
    localparam int BYTES_W          = 26;
    localparam int OP_W             = 2;
    localparam int ST_W             = 3;
    localparam int MAX_CAP          = 1 << IDX_W;
    localparam int POOL_ENTRIES_DEF = 1024;

    localparam logic [BS_W-1:0]  DOUBLE_FREE_MIN = BS_W'(8);
    localparam logic [CNT_W-1:0] COUNT_MAX       = {CNT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_RESET = 2'd2
    } op_t;

    typedef enum logic [ST_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_UNINIT    = 3'd1,
        STAT_EXHAUSTED = 3'd2,
        STAT_DOUBLE    = 3'd3,
        STAT_TOO_MANY  = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic             mark;
        logic [IDX_W-1:0] link;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } mem_rd_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } mem_wr_t;

    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   granted_index;
        status_t            status;
        logic [CNT_W-1:0]   outstanding;
        logic [BYTES_W-1:0] bytes_carved;
    } rsp_t;

endpackage

// File: src/fbpa_store.sv
// fbpa_store: entry memory holding the free list link and freed mark of each block
// one read port with registered data, one write port; depends on fbpa_pkg
`timescale 1ns / 1ps

module fbpa_store
    import fbpa_pkg::*;
#(
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
)
(
    input  logic    clk,
    input  mem_rd_t rd,
    input  mem_wr_t wr,
    output entry_t  rd_data
);

    localparam int POOL_CAP = (POOL_ENTRIES < MAX_CAP) ? POOL_ENTRIES : MAX_CAP;
    localparam int AW       = $clog2(POOL_CAP);

    entry_t mem [POOL_CAP];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/fbpa_core.sv
// fbpa_core: request sequencer, allocator state and read-modify-write of the entry store
// depends on fbpa_pkg; drives fbpa_store through its read and write ports
`timescale 1ns / 1ps

module fbpa_core
    import fbpa_pkg::*;
#(
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [OP_W-1:0]  operation,
    input  logic [IDX_W-1:0] entry_index,
    input  logic             out_busy,
    output logic             req_stall,
    input  logic             cfg_wr,
    input  logic [BS_W-1:0]  block_size,
    output mem_rd_t          mem_rd,
    output mem_wr_t          mem_wr,
    input  entry_t           mem_rd_data,
    output rsp_t             rsp
);

    localparam int POOL_CAP = (POOL_ENTRIES < MAX_CAP) ? POOL_ENTRIES : MAX_CAP;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(POOL_CAP);

    state_t            state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [BS_W-1:0]   block_size_reg, block_size_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic              nonempty_reg, nonempty_next;
    logic [CNT_W-1:0]  carve_reg, carve_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic                   accept;
    logic                   big_block;
    logic [CNT_W+BS_W-1:0]  product;

    assign accept    = req_valid && !out_busy;
    assign big_block = (block_size_reg >= DOUBLE_FREE_MIN);
    assign product   = (CNT_W+BS_W)'(carve_next) * (CNT_W+BS_W)'(block_size_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            block_size_reg <= '0;
            head_reg       <= '0;
            nonempty_reg   <= 1'b0;
            carve_reg      <= '0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            block_size_reg <= block_size_next;
            head_reg       <= head_next;
            nonempty_reg   <= nonempty_next;
            carve_reg      <= carve_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        idx_reg <= idx_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        idx_next          = idx_reg;
        block_size_next   = cfg_wr ? block_size : block_size_reg;
        head_next         = head_reg;
        nonempty_next     = nonempty_reg;
        carve_next        = carve_reg;
        count_next        = count_reg;
        req_stall         = 1'b1;
        mem_rd            = '0;
        mem_wr            = '0;
        rsp               = '0;
        rsp.status        = STAT_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = out_busy;
                if (accept)
                begin
                    op_next    = operation;
                    idx_next   = entry_index;
                    mem_rd.en  = 1'b1;
                    if (operation == OP_ALLOC)
                    begin
                        mem_rd.addr = nonempty_reg ? head_reg : carve_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        mem_rd.addr = entry_index;
                    end
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                unique case (op_reg)
                    OP_ALLOC:
                    begin
                        if (nonempty_reg)
                        begin
                            rsp.granted_index = head_reg;
                            mem_wr.en         = 1'b1;
                            mem_wr.addr       = head_reg;
                            mem_wr.data.mark  = 1'b0;
                            mem_wr.data.link  = mem_rd_data.link;
                            if (mem_rd_data.link == head_reg)
                            begin
                                nonempty_next = 1'b0;
                            end
                            else
                            begin
                                head_next = mem_rd_data.link;
                            end
                            if (count_reg != COUNT_MAX)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        else if (block_size_reg == '0)
                        begin
                            rsp.status = STAT_UNINIT;
                        end
                        else if (carve_reg >= CAP)
                        begin
                            rsp.status = STAT_EXHAUSTED;
                        end
                        else
                        begin
                            rsp.granted_index = carve_reg[IDX_W-1:0];
                            mem_wr.en         = 1'b1;
                            mem_wr.addr       = carve_reg[IDX_W-1:0];
                            mem_wr.data.mark  = 1'b0;
                            mem_wr.data.link  = mem_rd_data.link;
                            carve_next        = carve_reg + CNT_W'(1);
                            if (count_reg != COUNT_MAX)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                    end
                    OP_FREE:
                    begin
                        if ({1'b0, idx_reg} >= CAP)
                        begin
                            rsp.status = STAT_OK;
                        end
                        else if (big_block && mem_rd_data.mark)
                        begin
                            rsp.status = STAT_DOUBLE;
                        end
                        else
                        begin
                            mem_wr.en        = 1'b1;
                            mem_wr.addr      = idx_reg;
                            mem_wr.data.mark = big_block ? 1'b1 : mem_rd_data.mark;
                            mem_wr.data.link = nonempty_reg ? head_reg : idx_reg;
                            head_next        = idx_reg;
                            nonempty_next    = 1'b1;
                            if (count_reg == '0)
                            begin
                                rsp.status = STAT_TOO_MANY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                    end
                    OP_RESET:
                    begin
                        head_next     = '0;
                        nonempty_next = 1'b0;
                        carve_next    = '0;
                        count_next    = '0;
                    end
                    default:
                    begin
                        rsp.status = STAT_OK;
                    end
                endcase
                rsp.valid        = 1'b1;
                rsp.outstanding  = count_next;
                rsp.bytes_carved = product[BYTES_W-1:0];
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/fixed_block_pool_allocator_unit.sv
// fixed block pool allocator: one result per request, registered at the output
// a new request is taken only once the last one is through, as each request reads
// its entry from the entry store before writing it back
// reset clears the pool state and block_size; the entry store is not cleared
// and holds undefined data until written, so no clearing pass is needed
`timescale 1ns / 1ps

module fixed_block_pool_allocator_unit
    import fbpa_pkg::*;
#(
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [OP_W-1:0]    operation,
    input  logic [IDX_W-1:0]   entry_index,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [IDX_W-1:0]   granted_index,
    output logic [ST_W-1:0]    status,
    output logic [CNT_W-1:0]   outstanding,
    output logic [BYTES_W-1:0] bytes_carved,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [BS_W-1:0]    block_size
);

    mem_rd_t mem_rd;
    mem_wr_t mem_wr;
    entry_t  mem_rd_data;
    rsp_t    rsp;

    logic               rsp_valid_reg, rsp_valid_next;
    logic [IDX_W-1:0]   granted_reg, granted_next;
    logic [ST_W-1:0]    status_reg, status_next;
    logic [CNT_W-1:0]   outstanding_reg, outstanding_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;

    assign cfg_ready = 1'b1;

    fbpa_store #(
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_store (
        .clk     (clk),
        .rd      (mem_rd),
        .wr      (mem_wr),
        .rd_data (mem_rd_data)
    );

    fbpa_core #(
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .operation   (operation),
        .entry_index (entry_index),
        .out_busy    (rsp_valid_reg && rsp_stall),
        .req_stall   (req_stall),
        .cfg_wr      (cfg_valid && cfg_ready),
        .block_size  (block_size),
        .mem_rd      (mem_rd),
        .mem_wr      (mem_wr),
        .mem_rd_data (mem_rd_data),
        .rsp         (rsp)
    );

    always_comb
    begin
        rsp_valid_next   = rsp_valid_reg;
        granted_next     = granted_reg;
        status_next      = status_reg;
        outstanding_next = outstanding_reg;
        bytes_next       = bytes_reg;
        if (rsp.valid)
        begin
            rsp_valid_next   = 1'b1;
            granted_next     = rsp.granted_index;
            status_next      = rsp.status;
            outstanding_next = rsp.outstanding;
            bytes_next       = rsp.bytes_carved;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        granted_reg     <= granted_next;
        status_reg      <= status_next;
        outstanding_reg <= outstanding_next;
        bytes_reg       <= bytes_next;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign granted_index = granted_reg;
    assign status        = status_reg;
    assign outstanding   = outstanding_reg;
    assign bytes_carved  = bytes_reg;

endmodule

// File: src/fbpa_checker.sv
// fbpa_port_checks: port-level assertions on the pool allocator and their bind
// depends on fbpa_pkg and fixed_block_pool_allocator_unit
`timescale 1ns / 1ps

module fbpa_port_checks
    import fbpa_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input logic [IDX_W-1:0]   granted_index,
    input logic [ST_W-1:0]    status
);

    // one request in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
    else $error("request taken in the cycle after another");

    // result is shown once the request has passed the execute state and the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> ##1 rsp_valid)
    else $error("result missing after request");

    // refused requests grant nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != STAT_OK) |-> (granted_index == '0))
    else $error("index granted with error status");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == STAT_OK || status == STAT_UNINIT ||
                       status == STAT_EXHAUSTED || status == STAT_DOUBLE ||
                       status == STAT_TOO_MANY))
    else $error("status code out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(granted_index) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind fixed_block_pool_allocator_unit fbpa_port_checks u_fbpa_checker (.*);

// File: test/fbpa_checker.sv
// fbpa_checker: watches the request, result and block_size channels of the pool allocator,
// keeps its own copy of the pool state and compares every result with the predicted one
// depends on fbpa_pkg
`timescale 1ns / 1ps

module fbpa_checker
    import fbpa_pkg::*;
#(
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  logic [OP_W-1:0]    operation,
    input  logic [IDX_W-1:0]   entry_index,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  logic [IDX_W-1:0]   granted_index,
    input  logic [ST_W-1:0]    status,
    input  logic [CNT_W-1:0]   outstanding,
    input  logic [BYTES_W-1:0] bytes_carved,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [BS_W-1:0]    block_size,
    output int                 pending,
    output int                 errors
);

    localparam int CAP = (POOL_ENTRIES < MAX_CAP) ? POOL_ENTRIES : MAX_CAP;

    typedef struct {
        logic [IDX_W-1:0]   grant;
        status_t            stat;
        logic [CNT_W-1:0]   count;
        logic [BYTES_W-1:0] bytes;
    } pool_result_t;

    pool_result_t       due_results[$];
    pool_result_t       want;
    logic [BS_W-1:0]    size_reg;
    logic [IDX_W-1:0]   head;
    logic               list_live;
    logic [IDX_W-1:0]   links [MAX_CAP];
    logic               marks [MAX_CAP];
    logic [CNT_W-1:0]   carve_pos;
    logic [CNT_W-1:0]   live_count;
    int                 fail_tally;

    function automatic pool_result_t pool_apply(input logic [OP_W-1:0] op,
                                                input logic [IDX_W-1:0] idx);
        pool_result_t     r;
        logic [IDX_W-1:0] pick;
        logic [31:0]      product;
        r.grant = '0;
        r.stat  = STAT_OK;
        pick    = '0;
        case (op)
            OP_ALLOC:
            begin
                if (list_live)
                begin
                    pick = IDX_W'(head % CAP);
                    if (links[pick] == pick)
                        list_live = 1'b0;
                    else
                        head = links[pick];
                end
                else if (size_reg == '0)
                    r.stat = STAT_UNINIT;
                else if (carve_pos >= CAP)
                    r.stat = STAT_EXHAUSTED;
                else
                begin
                    pick      = carve_pos[IDX_W-1:0];
                    carve_pos = carve_pos + CNT_W'(1);
                end
                if (r.stat == STAT_OK)
                begin
                    marks[pick] = 1'b0;
                    if (live_count != COUNT_MAX)
                        live_count = live_count + CNT_W'(1);
                    r.grant = pick;
                end
            end
            OP_FREE:
            begin
                if (idx < CAP)
                begin
                    if (size_reg >= DOUBLE_FREE_MIN && marks[idx])
                        r.stat = STAT_DOUBLE;
                    else
                    begin
                        if (size_reg >= DOUBLE_FREE_MIN)
                            marks[idx] = 1'b1;
                        links[idx] = list_live ? head : idx;
                        head       = idx;
                        list_live  = 1'b1;
                        if (live_count == '0)
                            r.stat = STAT_TOO_MANY;
                        else
                            live_count = live_count - CNT_W'(1);
                    end
                end
            end
            OP_RESET:
            begin
                head       = '0;
                list_live  = 1'b0;
                carve_pos  = '0;
                live_count = '0;
            end
            default:
            begin
            end
        endcase
        product = carve_pos * size_reg;
        r.count = live_count;
        r.bytes = product[BYTES_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_results.delete();
            size_reg   = '0;
            head       = '0;
            list_live  = 1'b0;
            carve_pos  = '0;
            live_count = '0;
            fail_tally = 0;
            for (int i = 0; i < MAX_CAP; i++)
            begin
                links[i] = '0;
                marks[i] = 1'b0;
            end
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                size_reg = block_size;
            if (rsp_valid && !rsp_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result arrived with no request pending");
                    fail_tally++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (granted_index !== want.grant)
                    begin
                        $error("granted_index: expected %0d, actual %0d", want.grant,
                               granted_index);
                        fail_tally++;
                    end
                    if (status !== want.stat)
                    begin
                        $error("status: expected %0d, actual %0d", want.stat, status);
                        fail_tally++;
                    end
                    if (outstanding !== want.count)
                    begin
                        $error("outstanding: expected %0d, actual %0d", want.count,
                               outstanding);
                        fail_tally++;
                    end
                    if (bytes_carved !== want.bytes)
                    begin
                        $error("bytes_carved: expected %0d, actual %0d", want.bytes,
                               bytes_carved);
                        fail_tally++;
                    end
                end
            end
            if (req_valid && !req_stall)
                due_results.push_back(pool_apply(operation, entry_index));
            pending <= due_results.size();
            errors  <= fail_tally;
        end
    end

endmodule

// File: test/tb_fixed_block_pool_allocator_unit.sv
// tb_fixed_block_pool_allocator_unit: drives allocate, free, pool reset and unused requests
// with random idling on both channels and gives the verdict; checking is done in fbpa_checker
// depends on fbpa_pkg, fbpa_checker and fixed_block_pool_allocator_unit
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator_unit;
    import fbpa_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int POOL_CAP    = (POOL_ENTRIES_DEF < MAX_CAP) ? POOL_ENTRIES_DEF : MAX_CAP;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 10;
    localparam int PHASE_REQS  = 65;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [OP_W-1:0]    operation = '0;
    logic [IDX_W-1:0]   entry_index = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic [IDX_W-1:0]   granted_index;
    logic [ST_W-1:0]    status;
    logic [CNT_W-1:0]   outstanding;
    logic [BYTES_W-1:0] bytes_carved;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [BS_W-1:0]    block_size = '0;

    int                 pending;
    int                 errors;
    int                 cycles = 0;
    int                 sent = 0;
    int                 results = 0;
    int                 size_writes = 0;
    int                 gap_pct = 30;
    int                 hold_cnt = 0;
    logic               calm = 1'b0;
    logic [OP_W-1:0]    issued_ops[$];
    logic [OP_W-1:0]    done_op;
    logic [IDX_W-1:0]   held[$];
    logic [IDX_W-1:0]   recent_free = '0;
    logic [BS_W-1:0]    phase_sizes [PHASES] = '{16'd8, 16'd7, 16'd0, 16'd1, 16'hFFFF,
                                                 16'd9, 16'd300, 16'd8, 16'd4096, 16'd16};

    fixed_block_pool_allocator_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .operation     (operation),
        .entry_index   (entry_index),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .granted_index (granted_index),
        .status        (status),
        .outstanding   (outstanding),
        .bytes_carved  (bytes_carved),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .block_size    (block_size)
    );

    fbpa_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .operation     (operation),
        .entry_index   (entry_index),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .granted_index (granted_index),
        .status        (status),
        .outstanding   (outstanding),
        .bytes_carved  (bytes_carved),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .block_size    (block_size),
        .pending       (pending),
        .errors        (errors)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side stalls in bursts, or runs free for a while; it never stalls once calm is set
    always @(posedge clk)
    begin
        if (calm)
            rsp_stall <= 1'b0;
        else if (hold_cnt > 1)
            hold_cnt <= hold_cnt - 1;
        else if ($urandom_range(0, 2) == 0)
        begin
            rsp_stall <= 1'b1;
            hold_cnt  <= $urandom_range(1, 14);
        end
        else
        begin
            rsp_stall <= 1'b0;
            hold_cnt  <= $urandom_range(1, 30);
        end
    end

    // remember granted entries so later frees hit live blocks
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall && issued_ops.size() != 0)
        begin
            done_op = issued_ops.pop_front();
            if (done_op == OP_ALLOC && status == STAT_OK)
                held.push_back(granted_index);
            results++;
        end
    end

    task automatic send(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
        if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req_valid   <= 1'b1;
        operation   <= op;
        entry_index <= idx;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        issued_ops.push_back(op);
        sent++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_size(input logic [BS_W-1:0] value);
        drain();
        cfg_valid  <= 1'b1;
        block_size <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        size_writes++;
    endtask

    task automatic random_request();
        int               pick;
        int               k;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(0, 99);
        idx  = IDX_W'($urandom_range(0, 1023));
        if (pick < 48)
            send(OP_ALLOC, idx);
        else if (pick < 80 && held.size() != 0)
        begin
            k = $urandom_range(0, held.size() - 1);
            recent_free = held[k];
            held.delete(k);
            send(OP_FREE, recent_free);
        end
        else if (pick < 86)
            send(OP_FREE, recent_free);
        else if (pick < 95)
            send(OP_FREE, idx);
        else if (pick < 97)
        begin
            held.delete();
            send(OP_RESET, idx);
        end
        else
            send(OP_UNUSED, idx);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pool not initialized: frees link entries, allocate still pops them
        send(OP_ALLOC, 10'h3FF);
        send(OP_UNUSED, 10'h000);
        send(OP_FREE, 10'h3FF);
        send(OP_FREE, 10'h000);
        send(OP_ALLOC, 10'h155);
        send(OP_ALLOC, 10'h2AA);
        send(OP_ALLOC, 10'h000);
        send(OP_RESET, 10'h2AA);

        // largest block size, carve the whole pool and run past its end
        set_size(16'hFFFF);
        gap_pct = 20;
        repeat (POOL_CAP + 2)
            send(OP_ALLOC, IDX_W'($urandom));
        send(OP_FREE, 10'h3FF);
        send(OP_FREE, 10'h3FF);
        send(OP_FREE, 10'h000);
        send(OP_ALLOC, 10'h000);
        send(OP_ALLOC, 10'h000);
        send(OP_ALLOC, 10'h000);

        // repeated free just below and at the double free threshold
        set_size(16'd7);
        send(OP_FREE, 10'd9);
        send(OP_FREE, 10'd9);
        send(OP_ALLOC, 10'd0);
        send(OP_ALLOC, 10'd0);
        set_size(16'd8);
        send(OP_FREE, 10'd9);
        send(OP_FREE, 10'd9);
        send(OP_RESET, 10'd0);

        // a two entry cycle in the free list drives the count into saturation
        set_size(16'd1);
        repeat (3)
            send(OP_ALLOC, 10'd0);
        send(OP_FREE, 10'd0);
        send(OP_FREE, 10'd1);
        send(OP_FREE, 10'd0);
        repeat (int'(COUNT_MAX) + 8)
            send(OP_ALLOC, IDX_W'($urandom));
        send(OP_FREE, 10'd2);
        send(OP_RESET, 10'd0);
        held.delete();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 6)
                set_size(BS_W'($urandom));
            else
                set_size(phase_sizes[p]);
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 15;
                default: gap_pct = 40;
            endcase
            if (p == PHASES - 1)
                calm = 1'b1;
            repeat (PHASE_REQS)
                random_request();
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("run: %0d requests, %0d results, %0d block_size writes", sent, results,
                 size_writes);
        $display("reached: uninitialized pool, full carve and exhaustion, %s",
                 "double and excess frees, count saturation");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
